/* design/ple_pkg.sv */
// shared types and codes for the positional list engine
// no dependencies; imported by ple_cell, positional_list_engine_core and the testbench
package ple_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [7:0] POS_LAST = 8'hFF;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_READ,
		OP_SEARCH
	} op_t;

	typedef struct packed {
		logic       valid;
		op_t        op;
		logic [1:0] status;
		logic       found;
	} ctrl_t;

endpackage

/* design/ple_cell.sv */
// one list cell: holds one entry and passes the command token to its right neighbor
// depends on ple_pkg
module ple_cell import ple_pkg::*; #(
	parameter int IW    = 6,
	parameter int CW    = 7,
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl_in,
	input  logic [IW-1:0] at_in,
	input  logic [CW-1:0] cnt_in,
	input  logic [31:0]   key_in,
	input  logic [31:0]   data_in,
	input  logic [IW-1:0] fidx_in,
	input  logic [31:0]   next_entry,
	output logic [31:0]   entry,
	output ctrl_t         ctrl_out,
	output logic [IW-1:0] at_out,
	output logic [CW-1:0] cnt_out,
	output logic [31:0]   key_out,
	output logic [31:0]   data_out,
	output logic [IW-1:0] fidx_out
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
	localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

	logic [31:0]   entry_q;
	ctrl_t         ctrl_q;
	logic [IW-1:0] at_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   key_q;
	logic [31:0]   data_q;
	logic [IW-1:0] fidx_q;

	logic [31:0]   entry_d;
	ctrl_t         ctrl_d;
	logic [31:0]   data_d;
	logic [IW-1:0] fidx_d;

	always_comb begin
		entry_d = entry_q;
		ctrl_d  = ctrl_in;
		data_d  = data_in;
		fidx_d  = fidx_in;
		if (ctrl_in.valid) begin
			case (ctrl_in.op)
				OP_INSERT: begin
					if (MY_IDX >= at_in) begin
						entry_d = data_in;
						data_d  = entry_q;
					end
				end
				OP_REMOVE: begin
					if (MY_IDX == at_in) begin
						data_d = entry_q;
					end
					if (MY_IDX >= at_in) begin
						entry_d = next_entry;
					end
				end
				OP_READ: begin
					if (MY_IDX == at_in) begin
						data_d = entry_q;
					end
				end
				OP_SEARCH: begin
					if (!ctrl_in.found && (MY_CNT < cnt_in) && (entry_q == key_in)) begin
						ctrl_d.found  = 1'b1;
						ctrl_d.status = ST_OK;
						fidx_d        = MY_IDX;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		at_q    <= at_in;
		cnt_q   <= cnt_in;
		key_q   <= key_in;
		data_q  <= data_d;
		fidx_q  <= fidx_d;
	end

	assign entry    = entry_q;
	assign ctrl_out = ctrl_q;
	assign at_out   = at_q;
	assign cnt_out  = cnt_q;
	assign key_out  = key_q;
	assign data_out = data_q;
	assign fidx_out = fidx_q;

endmodule

/* design/positional_list_engine_core.sv */
// top level of the positional list engine: command decode, length register, chain of cells
// depends on ple_pkg and ple_cell
//
// A command transfers at a rising edge with start high and busy low. It then travels the row
// of CAPACITY cells one cell per cycle, each cell shifting, capturing or comparing its own
// entry as the command passes. Its result is on the result ports when it leaves the last cell,
// marked by done, for exactly one cycle, and cannot be held off. busy stays high through that
// result cycle, so the next command can transfer in the cycle after it at the earliest: the
// engine holds one command at a time. Bad positions, an empty list or a full list take the
// same time.
module positional_list_engine_core import ple_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        mode,
	input  logic signed [7:0]                 position,
	input  logic signed [31:0]                value_in,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [$clog2(CAPACITY+1)-1:0]     length,
	output logic signed [31:0]                value_out,
	output logic [$clog2(CAPACITY)-1:0]       found_index
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

	logic          busy_q;
	logic [CW-1:0] count_q;

	ctrl_t         ctrl_c [0:CAPACITY];
	logic [IW-1:0] at_c   [0:CAPACITY];
	logic [CW-1:0] cnt_c  [0:CAPACITY];
	logic [31:0]   key_c  [0:CAPACITY];
	logic [31:0]   data_c [0:CAPACITY];
	logic [IW-1:0] fidx_c [0:CAPACITY];
	logic [31:0]   ent_c  [0:CAPACITY-1];

	logic          accept;
	logic          pos_last;
	logic          pos_bad;
	logic          pos_ge;
	logic          empty;
	logic          full;
	logic [CW-1:0] count_d;
	ctrl_t         launch;
	logic [IW-1:0] launch_at;
	logic [31:0]   launch_data;

	assign accept   = start && !busy_q;
	assign pos_last = (position == POS_LAST);
	assign pos_bad  = position[7] && !pos_last;
	assign pos_ge   = (PW'(position[6:0]) >= PW'(count_q));
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_FULL);

	always_comb begin
		launch        = '0;
		launch.valid  = accept;
		launch.op     = OP_NONE;
		launch.status = ST_OK;
		launch_at     = IW'(position[6:0]);
		launch_data   = '0;
		count_d       = count_q;
		case (mode)
			MODE_INSERT: begin
				if (pos_bad) begin
					launch.status = ST_BADPOS;
				end else if (full) begin
					launch.status = ST_FULL;
				end else begin
					launch.op = OP_INSERT;
					launch_data = $unsigned(value_in);
					if (pos_last || pos_ge) begin
						launch_at = IW'(count_q);
					end
					count_d = CW'(count_q + 1'b1);
				end
			end
			MODE_REMOVE, MODE_READ: begin
				if (pos_bad || empty || (!pos_last && pos_ge)) begin
					launch.status = ST_BADPOS;
				end else begin
					launch.op = (mode == MODE_REMOVE) ? OP_REMOVE : OP_READ;
					if (pos_last) begin
						launch_at = IW'(count_q - 1'b1);
					end
					if (mode == MODE_REMOVE) begin
						count_d = CW'(count_q - 1'b1);
					end
				end
			end
			MODE_SEARCH: begin
				launch.op     = OP_SEARCH;
				launch.status = ST_NOTFOUND;
			end
			default: begin
			end
		endcase
	end

	assign ctrl_c[0] = launch;
	assign at_c[0]   = launch_at;
	assign cnt_c[0]  = count_q;
	assign key_c[0]  = $unsigned(value_in);
	assign data_c[0] = launch_data;
	assign fidx_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] nbr;
		if (i == CAPACITY - 1) begin : g_last
			assign nbr = ent_c[i];
		end else begin : g_mid
			assign nbr = ent_c[i+1];
		end
		ple_cell #(
			.IW    (IW),
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl_in    (ctrl_c[i]),
			.at_in      (at_c[i]),
			.cnt_in     (cnt_c[i]),
			.key_in     (key_c[i]),
			.data_in    (data_c[i]),
			.fidx_in    (fidx_c[i]),
			.next_entry (nbr),
			.entry      (ent_c[i]),
			.ctrl_out   (ctrl_c[i+1]),
			.at_out     (at_c[i+1]),
			.cnt_out    (cnt_c[i+1]),
			.key_out    (key_c[i+1]),
			.data_out   (data_c[i+1]),
			.fidx_out   (fidx_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				count_q <= count_d;
			end else if (ctrl_c[CAPACITY].valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy        = busy_q;
	assign done        = ctrl_c[CAPACITY].valid;
	assign status      = ctrl_c[CAPACITY].status;
	assign length      = count_q;
	assign value_out   = (ctrl_c[CAPACITY].op == OP_INSERT) ? '0 : $signed(data_c[CAPACITY]);
	assign found_index = fidx_c[CAPACITY];

endmodule

/* dv/tb_positional_list_engine_core.sv */
// self-checking testbench for positional_list_engine_core: insert, remove, read and search
// commands checked against a shadow list kept in the testbench; depends on ple_pkg and the core
module tb_positional_list_engine_core;
	import ple_pkg::*;

	localparam int CAP = 64;
	localparam int RANDOM_CMDS = 1430;
	localparam int QUIET_TAIL = 150;

	typedef struct {
		logic [1:0]        mode;
		logic signed [7:0] pos;
		logic signed [31:0] val;
		int                gap;
		bit                gap_on_free;
		bit                drain;
	} list_cmd_t;

	typedef struct {
		logic [1:0]         status;
		logic [6:0]         length;
		logic signed [31:0] value_out;
		logic [5:0]         found_index;
	} list_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         mode = MODE_INSERT;
	logic signed [7:0]  position = '0;
	logic signed [31:0] value_in = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [6:0]         length;
	logic signed [31:0] value_out;
	logic [5:0]         found_index;

	list_cmd_t cmd_queue[$];
	list_res_t due_results[$];

	logic signed [31:0] shadow_cells [0:CAP-1];
	int                 shadow_count = 0;
	int                 est_len = 0;
	int                 errors = 0;

	int        idle_left = 0;
	bit        idle_free = 1'b0;
	bit        gap_taken = 1'b0;
	bit        moved;
	bit        go;
	list_cmd_t nxt;
	list_res_t want;

	positional_list_engine_core #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.position(position),
		.value_in(value_in),
		.done(done),
		.status(status),
		.length(length),
		.value_out(value_out),
		.found_index(found_index)
	);

	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow list: applies one command and returns the result it gives
	function automatic list_res_t list_step(input logic [1:0] m, input logic signed [7:0] p,
			input logic signed [31:0] v);
		list_res_t r;
		int at;
		r.status = ST_OK;
		r.value_out = '0;
		r.found_index = '0;
		if (m == MODE_SEARCH) begin
			r.status = ST_NOTFOUND;
			// scan downward so the lowest matching index wins
			for (int i = shadow_count - 1; i >= 0; i--) begin
				if (shadow_cells[i] == v) begin
					r.status = ST_OK;
					r.found_index = 6'(i);
				end
			end
		end else if (p < -1) begin
			r.status = ST_BADPOS;
		end else if (m == MODE_INSERT) begin
			if (shadow_count >= CAP) begin
				r.status = ST_FULL;
			end else begin
				at = (p == -1 || p >= shadow_count) ? shadow_count : int'(p);
				for (int i = shadow_count; i > at; i--)
					shadow_cells[i] = shadow_cells[i-1];
				shadow_cells[at] = v;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0 || (p != -1 && p >= shadow_count)) begin
				r.status = ST_BADPOS;
			end else begin
				at = (p == -1) ? shadow_count - 1 : int'(p);
				r.value_out = shadow_cells[at];
				if (m == MODE_REMOVE) begin
					for (int i = at; i < shadow_count - 1; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
				end
			end
		end
		r.length = 7'(shadow_count);
		return r;
	endfunction

	// queues a command and tracks the rough list length used to aim positions
	function automatic void queue_cmd(input logic [1:0] m, input logic signed [7:0] p,
			input logic signed [31:0] v, input int gap, input bit free, input bit drain);
		list_cmd_t c;
		c.mode = m;
		c.pos = p;
		c.val = v;
		c.gap = gap;
		c.gap_on_free = free;
		c.drain = drain;
		cmd_queue.push_back(c);
		if (m == MODE_INSERT && p >= -1 && est_len < CAP)
			est_len++;
		else if (m == MODE_REMOVE && p >= -1 && est_len > 0 && (p == -1 || p < est_len))
			est_len--;
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 1) == 0)
			return $urandom;
		case ($urandom_range(0, 11))
			0: return 32'sd0;
			1: return 32'sd1;
			2: return -32'sd1;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5: return 32'sd5;
			6: return 32'sd42;
			7: return 32'sd1000;
			8: return -32'sd1000;
			9: return 32'h5555_5555;
			10: return 32'hAAAA_AAAA;
			default: return 32'sd7;
		endcase
	endfunction

	// hi is the highest position that addresses an element or the append slot
	function automatic logic signed [7:0] pick_pos(input int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return POS_LAST;
		if (r < 17)
			return 8'(-int'($urandom_range(2, 128)));
		if (r < 24)
			return 8'($urandom_range(hi + 1, 127));
		return 8'($urandom_range(0, hi));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_INSERT;
			position <= '0;
			value_in <= '0;
			idle_left = 0;
			gap_taken = 1'b0;
		end else begin
			moved = start && !busy;
			if (moved)
				due_results.push_back(list_step(mode, position, value_in));
			if (moved || !start) begin
				go = 1'b0;
				if (idle_left > 0) begin
					if (!(idle_free && busy))
						idle_left--;
				end else if (cmd_queue.size() > 0) begin
					nxt = cmd_queue[0];
					if (!(nxt.drain && (due_results.size() != 0 || done))) begin
						if (nxt.gap > 0 && !gap_taken) begin
							idle_left = nxt.gap;
							idle_free = nxt.gap_on_free;
							gap_taken = 1'b1;
						end else begin
							void'(cmd_queue.pop_front());
							gap_taken = 1'b0;
							mode <= nxt.mode;
							position <= nxt.pos;
							value_in <= nxt.val;
							go = 1'b1;
						end
					end
				end
				start <= go;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result transfer: status %0d length %0d value %0d",
					$time, status, length, value_out);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					errors++;
				end
				if (length !== want.length) begin
					$display("%0t: length expected %0d actual %0d", $time, want.length, length);
					errors++;
				end
				if (value_out !== want.value_out) begin
					$display("%0t: value_out expected %0d actual %0d", $time,
						want.value_out, value_out);
					errors++;
				end
				if (found_index !== want.found_index) begin
					$display("%0t: found_index expected %0d actual %0d", $time,
						want.found_index, found_index);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		int seg_len;
		int kind;
		int r;
		int gap;
		int hi;
		bit quiet;
		bit drain;
		logic [1:0] m;
		logic signed [7:0] p;

		// directed: empty list, bad positions, appends, duplicates, searches, past-end access
		queue_cmd(MODE_READ, POS_LAST, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, 8'sd0, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_SEARCH, 8'sd0, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_INSERT, -8'sd128, 32'sd1, 0, 0, 0);
		queue_cmd(MODE_INSERT, -8'sd2, 32'sd1, 0, 0, 0);
		queue_cmd(MODE_INSERT, 8'sd127, 32'h7FFF_FFFF, 0, 0, 0);
		queue_cmd(MODE_INSERT, POS_LAST, 32'h8000_0000, 0, 0, 0);
		queue_cmd(MODE_INSERT, 8'sd0, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_INSERT, 8'sd1, -32'sd1, 0, 0, 0);
		queue_cmd(MODE_INSERT, 8'sd2, -32'sd1, 0, 0, 0);
		queue_cmd(MODE_SEARCH, 8'sd3, -32'sd1, 0, 0, 0);
		queue_cmd(MODE_SEARCH, 8'sd0, 32'h1234_5678, 0, 0, 0);
		queue_cmd(MODE_SEARCH, POS_LAST, 32'h8000_0000, 0, 0, 0);
		queue_cmd(MODE_READ, 8'sd0, 32'hFFFF_FFFF, 0, 0, 0);
		queue_cmd(MODE_READ, POS_LAST, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_READ, 8'sd4, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_READ, 8'sd5, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_READ, -8'sd128, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_READ, 8'sd127, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, 8'sd2, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, POS_LAST, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, 8'sd64, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, -8'sd3, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_REMOVE, 8'sd0, 32'sd0, 0, 0, 0);
		queue_cmd(MODE_SEARCH, -8'sd128, 32'h7FFF_FFFF, 0, 0, 0);

		// random: segments that grow, shrink or churn the list
		n = 0;
		while (n < RANDOM_CMDS) begin
			if (n == 0) begin
				kind = 0;
				seg_len = 90;
				drain = 1'b1;
			end else begin
				kind = $urandom_range(0, 2);
				seg_len = $urandom_range(20, 80);
				drain = ($urandom_range(0, 4) == 0);
			end
			quiet = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < seg_len && n < RANDOM_CMDS; k++) begin
				r = $urandom_range(0, 99);
				case (kind)
					0: m = (r < 65) ? MODE_INSERT : (r < 75) ? MODE_REMOVE :
						(r < 87) ? MODE_READ : MODE_SEARCH;
					1: m = (r < 15) ? MODE_INSERT : (r < 70) ? MODE_REMOVE :
						(r < 85) ? MODE_READ : MODE_SEARCH;
					default: m = (r < 35) ? MODE_INSERT : (r < 60) ? MODE_REMOVE :
						(r < 80) ? MODE_READ : MODE_SEARCH;
				endcase
				hi = (m == MODE_INSERT) ? est_len : ((est_len > 0) ? est_len - 1 : 0);
				p = (m == MODE_SEARCH) ? 8'($urandom) : pick_pos(hi);
				gap = 0;
				if (!quiet && n < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 99) < 35)
					gap = $urandom_range(1, 4);
				queue_cmd(m, p, pick_value(), gap, $urandom_range(0, 1), drain && k == 0);
				n++;
			end
		end

		@(posedge arst_n);
		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (CAP + 5) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, due_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
